[rtl/fwl_pkg.sv]
`default_nettype none

package fwl_pkg;

	// Store geometry
	localparam int DEPTH   = 16;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int STAMP_W = 64;
	localparam int THR_W   = 8;
	localparam int REC_W   = 5;
	localparam int EXT_W   = CNT_W + THR_W;
	localparam int OP_W    = 2;
	localparam int REG_W   = 2;

	// Opcodes
	localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	// Register indexes
	localparam logic [REG_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [REG_W-1:0] REG_WINDOW    = 2'd1;
	localparam logic [REG_W-1:0] REG_UNLOCK    = 2'd2;

	// Reset values of the registers
	localparam logic [THR_W-1:0]   THR_RESET    = 8'd5;
	localparam logic [STAMP_W-1:0] WINDOW_RESET = 64'd300;
	localparam logic [STAMP_W-1:0] UNLOCK_RESET = 64'd300;

	// Scan modes
	localparam logic [1:0] MODE_MAX = 2'd0;
	localparam logic [1:0] MODE_MIN = 2'd1;
	localparam logic [1:0] MODE_CNT = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic       load_now;
		logic       append;
		logic       clear;
		logic       scan_start;
		logic       scan_en;
		logic [1:0] scan_mode;
		logic       calc_floor;
		logic       write_slot;
		logic       load_out;
	} fwl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic full;
		logic scan_done;
	} fwl_sts_t;

endpackage

`default_nettype wire

[rtl/fwl_req_if.sv]
`default_nettype none

interface fwl_req_if;
	import fwl_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    opcode;
	logic [STAMP_W-1:0] time_now;

	modport source (output valid, output opcode, output time_now, input ready);
	modport sink   (input valid, input opcode, input time_now, output ready);
endinterface

`default_nettype wire

[rtl/fwl_rsp_if.sv]
`default_nettype none

interface fwl_rsp_if;
	import fwl_pkg::*;

	logic               valid;
	logic               ready;
	logic               locked;
	logic [STAMP_W-1:0] lock_since;
	logic [REC_W-1:0]   recent_failures;

	modport source (output valid, output locked, output lock_since,
		output recent_failures, input ready);
	modport sink   (input valid, input locked, input lock_since,
		input recent_failures, output ready);
endinterface

`default_nettype wire

[rtl/fwl_datapath.sv]
`default_nettype none

module fwl_datapath import fwl_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fwl_cmd_t           cmd,
	output fwl_sts_t                sts,
	input  wire logic [STAMP_W-1:0] time_now,
	input  wire logic               cfg_we,
	input  wire logic [REG_W-1:0]   cfg_idx,
	input  wire logic [STAMP_W-1:0] cfg_wdata,
	output logic                    locked,
	output logic [STAMP_W-1:0]      lock_since,
	output logic [REC_W-1:0]        recent_failures
);

	logic [THR_W-1:0]   thr_q;
	logic [STAMP_W-1:0] win_q;
	logic [STAMP_W-1:0] unl_q;
	logic [CNT_W-1:0]   count_q;
	logic [STAMP_W-1:0] now_q;
	logic [STAMP_W-1:0] mem [DEPTH];
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [STAMP_W-1:0] wr_data;
	logic [CNT_W-1:0]   idx_q;
	logic               issue;
	logic               rvld_s1;
	logic [STAMP_W-1:0] rdat_s1;
	logic [IDX_W-1:0]   ridx_s1;
	logic [STAMP_W-1:0] latest_q;
	logic [STAMP_W-1:0] min_q;
	logic [IDX_W-1:0]   slot_q;
	logic [CNT_W-1:0]   hits_q;
	logic [STAMP_W-1:0] floor_q;
	logic [STAMP_W:0]   unlock_at;
	logic               unlocked;
	logic [EXT_W-1:0]   cnt_ext;
	logic [EXT_W-1:0]   thr_ext;
	logic               locked_d;
	logic               locked_q;
	logic [STAMP_W-1:0] start_q;
	logic [REC_W-1:0]   recent_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			win_q <= WINDOW_RESET;
			unl_q <= UNLOCK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_THRESHOLD: thr_q <= cfg_wdata[THR_W-1:0];
				REG_WINDOW:    win_q <= cfg_wdata;
				REG_UNLOCK:    unl_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Fill count of the stamp store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.append) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	assign sts.full = (count_q == CNT_W'(DEPTH));

	// Time of the item in progress
	always_ff @(posedge clk) begin
		if (cmd.load_now) begin
			now_q <= time_now;
		end
	end

	// Store write port: append at the fill count, or replace the oldest stamp
	assign wr_en   = cmd.append | cmd.write_slot;
	assign wr_addr = cmd.append ? count_q[IDX_W-1:0] : slot_q;
	assign wr_data = cmd.append ? time_now : now_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Scan pointer walks the valid entries, one read a cycle
	assign issue = cmd.scan_en && (idx_q != count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= issue;
			if (cmd.scan_start) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rdat_s1 <= mem[idx_q[IDX_W-1:0]];
			ridx_s1 <= idx_q[IDX_W-1:0];
		end
	end

	assign sts.scan_done = (idx_q == count_q) && !rvld_s1;

	// Scan accumulators: latest stamp, oldest stamp and slot, hits above floor
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			unique case (cmd.scan_mode)
				MODE_MAX: latest_q <= '0;
				MODE_MIN: begin
					min_q  <= '1;
					slot_q <= '0;
				end
				MODE_CNT: hits_q <= '0;
				default: ;
			endcase
		end else if (rvld_s1) begin
			unique case (cmd.scan_mode)
				MODE_MAX: begin
					if (rdat_s1 > latest_q) begin
						latest_q <= rdat_s1;
					end
				end
				MODE_MIN: begin
					if (rdat_s1 < min_q) begin
						min_q  <= rdat_s1;
						slot_q <= ridx_s1;
					end
				end
				MODE_CNT: begin
					if (rdat_s1 > floor_q) begin
						hits_q <= hits_q + CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Window floor, saturating at zero
	always_ff @(posedge clk) begin
		if (cmd.calc_floor) begin
			floor_q <= (latest_q >= win_q) ? (latest_q - win_q) : '0;
		end
	end

	// Unlock check and threshold compare
	assign unlock_at = {1'b0, latest_q} + {1'b0, unl_q};
	assign unlocked  = !unlock_at[STAMP_W] && (unlock_at[STAMP_W-1:0] < now_q);
	assign cnt_ext   = unlocked ? '0 : EXT_W'(hits_q);
	assign thr_ext   = EXT_W'(thr_q);
	assign locked_d  = (cnt_ext >= thr_ext);

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			locked_q <= locked_d;
			start_q  <= locked_d ? latest_q : '0;
			recent_q <= cnt_ext[REC_W-1:0];
		end
	end

	assign locked          = locked_q;
	assign lock_since      = start_q;
	assign recent_failures = recent_q;

endmodule

`default_nettype wire

[rtl/fwl_ctrl.sv]
`default_nettype none

module fwl_ctrl import fwl_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	input  wire logic [OP_W-1:0] req_opcode,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	input  wire fwl_sts_t        sts,
	output fwl_cmd_t             cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MIN  = 3'd1;
	localparam logic [2:0] S_MAX  = 3'd2;
	localparam logic [2:0] S_CNT  = 3'd3;
	localparam logic [2:0] S_RES  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_vld_q;

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		cmd.scan_mode = MODE_MAX;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_now = 1'b1;
					unique case (req_opcode)
						OP_RECORD: begin
							if (sts.full) begin
								cmd.scan_start = 1'b1;
								cmd.scan_mode  = MODE_MIN;
								state_d        = S_MIN;
							end else begin
								cmd.append = 1'b1;
							end
						end
						OP_QUERY: begin
							cmd.scan_start = 1'b1;
							cmd.scan_mode  = MODE_MAX;
							state_d        = S_MAX;
						end
						OP_CLEAR: cmd.clear = 1'b1;
						default: ;
					endcase
				end
			end
			S_MIN: begin
				cmd.scan_en   = 1'b1;
				cmd.scan_mode = MODE_MIN;
				if (sts.scan_done) begin
					cmd.write_slot = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_MAX: begin
				cmd.scan_en   = 1'b1;
				cmd.scan_mode = MODE_MAX;
				if (sts.scan_done) begin
					cmd.calc_floor = 1'b1;
					cmd.scan_start = 1'b1;
					cmd.scan_mode  = MODE_CNT;
					state_d        = S_CNT;
				end
			end
			S_CNT: begin
				cmd.scan_en   = 1'b1;
				cmd.scan_mode = MODE_CNT;
				if (sts.scan_done) begin
					state_d = S_RES;
				end
			end
			S_RES: begin
				cmd.scan_mode = MODE_CNT;
				if (!out_vld_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_vld_q;

endmodule

`default_nettype wire

[rtl/failure_window_lockout_core.sv]
// Channel  Dir  Payload                                         Transfer
// req      in   opcode, time_now                                valid & ready
// rsp      out  locked, lock_since, recent_failures             valid & ready
// cfg      in   cfg_idx, cfg_wdata                              cfg_we
//
// One item is worked at a time; the stamp store has one read port, read data registered.
// Record with room and clear take effect on acceptance; record when full runs an oldest-entry scan.
// Query runs a latest scan, then a window count.
// Reset clears the fill count and restores register defaults; the store needs no clearing.
// A result waits in its output register; new items are taken while it waits, and only
// the next query's final step stalls on it.
`default_nettype none

module failure_window_lockout_core import fwl_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	fwl_req_if.sink                 req,
	fwl_rsp_if.source               rsp,
	input  wire logic               cfg_we,
	input  wire logic [REG_W-1:0]   cfg_idx,
	input  wire logic [STAMP_W-1:0] cfg_wdata
);

	fwl_cmd_t cmd;
	fwl_sts_t sts;

	// Sequencer
	fwl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_opcode (req.opcode),
		.req_ready  (req.ready),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Store, scans and result
	fwl_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.time_now        (req.time_now),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.locked          (rsp.locked),
		.lock_since      (rsp.lock_since),
		.recent_failures (rsp.recent_failures)
	);

endmodule

`default_nettype wire
